// ===== rtl/gwm_pkg.sv =====
// Types and constants shared by the glob wildcard matcher.
`timescale 1ns / 1ps
package gwm_pkg;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] kind_t;
	typedef logic [1:0] err_t;

	localparam cmd_t CMD_START   = 2'd0;
	localparam cmd_t CMD_PATTERN = 2'd1;
	localparam cmd_t CMD_TEXT    = 2'd2;

	localparam kind_t KIND_LIT  = 2'd0;
	localparam kind_t KIND_ANY  = 2'd1;
	localparam kind_t KIND_STAR = 2'd2;

	localparam err_t ERR_NONE       = 2'd0;
	localparam err_t ERR_OVERFLOW   = 2'd1;
	localparam err_t ERR_AFTER_TEXT = 2'd2;
	localparam err_t ERR_ZERO_TEXT  = 2'd3;

	localparam logic [7:0] ESC_BYTE   = 8'h5C;
	localparam logic [7:0] STAR_BYTE  = 8'h2A;
	localparam logic [7:0] QMARK_BYTE = 8'h3F;

	localparam int IN_BYTES  = 3;
	localparam int OUT_BYTES = 2;

endpackage

// ===== rtl/glob_wildcard_matcher.sv =====
// Glob matcher with star, question mark and backslash escape over a streamed pattern and text.
//
// Usage: every request on the s_ side carries a command (start, pattern byte or text byte).
// Pattern bytes are compiled into up to MAX_TOKENS tokens (literal, any, star); text bytes
// then update a set of active pattern positions for all positions at once. Each request
// gives exactly one result on the m_ side: whether the text so far matches the whole
// pattern, an error code and the number of tokens held.
// Pipeline: a request passes an input register, then a result register, to its result.
// Throughput: one request per cycle unless a low m_tready stalls the result register; the
// active set, the byte compares of all token lanes and the star closure (a prefix network
// of log2(MAX_TOKENS+1) levels) sit between the input register and the result register.
// Reset: arst_n clears both pipeline stages, empties the token list and leaves only
// position zero active, the same state as a start command.
// Stall: when m_tready is low the result register holds; the input register still takes
// one more request, and s_tready drops only when both registers are full.
`timescale 1ns / 1ps
module glob_wildcard_matcher #(
	parameter int MAX_TOKENS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [1:0] cmd, [9:2] pattern_char, [17:10] text_char
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [0] matched, [2:1] error_code, [8:3] tokens_held
);

	localparam int AW = MAX_TOKENS + 1;
	localparam int CW = $clog2(MAX_TOKENS + 1);
	localparam int LV = $clog2(AW);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TOKENS);

	// input stage
	logic                v_s1;
	gwm_pkg::cmd_t       cmd_s1;
	logic [7:0]          pc_s1;
	logic [7:0]          tc_s1;

	// matcher state
	gwm_pkg::kind_t      kind_q [MAX_TOKENS];
	logic [7:0]          byte_q [MAX_TOKENS];
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       active_q;
	logic                esc_q;
	logic                begun_q;

	// result register
	logic                out_v_q;
	logic                matched_q;
	gwm_pkg::err_t       err_q;
	logic [5:0]          held_q;

	logic                s_acc;
	logic                adv;
	logic                step;

	logic                esc_fill;
	logic [CW-1:0]       count_adv;
	logic [AW-1:0]       adv_raw;
	logic [AW-1:0]       adv_closed;
	logic [MAX_TOKENS-1:0] star_v;

	logic                wr_en;
	gwm_pkg::kind_t      wr_kind;
	logic [7:0]          wr_byte;
	logic [CW-1:0]       count_n;
	logic [AW-1:0]       active_n;
	logic                esc_n;
	logic                begun_n;
	gwm_pkg::err_t       err_n;
	logic                matched_n;

	assign adv      = !out_v_q || m_tready;
	assign s_tready = !v_s1 || adv;
	assign s_acc    = s_tvalid && s_tready;
	assign step     = v_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			cmd_s1 <= s_tdata[1:0];
			pc_s1  <= s_tdata[9:2];
			tc_s1  <= s_tdata[17:10];
		end
	end

	// First text byte with a backslash still pending: it becomes a literal backslash
	// at the next free slot before the byte is matched.
	assign esc_fill  = (cmd_s1 == gwm_pkg::CMD_TEXT) && (tc_s1 != 8'd0) && !begun_q && esc_q;
	assign count_adv = count_q + CW'(esc_fill);

	// one lane per token: step the active set by the text byte
	always_comb begin
		gwm_pkg::kind_t k;
		logic [7:0]     b;
		logic           sv;
		adv_raw = '0;
		star_v  = '0;
		for (int i = 0; i < MAX_TOKENS; i++) begin
			if (esc_fill && (count_q == CW'(i))) begin
				k = gwm_pkg::KIND_LIT;
				b = gwm_pkg::ESC_BYTE;
			end else begin
				k = kind_q[i];
				b = byte_q[i];
			end
			sv        = active_q[i] && (CW'(i) < count_adv);
			star_v[i] = (k == gwm_pkg::KIND_STAR) && (CW'(i) < count_adv);
			if (k == gwm_pkg::KIND_STAR) begin
				adv_raw[i] = adv_raw[i] | sv;
			end else if ((k == gwm_pkg::KIND_ANY) || (b == tc_s1)) begin
				adv_raw[i+1] = adv_raw[i+1] | sv;
			end
		end
	end

	// star closure as a prefix network: an active position runs on through a chain of stars
	always_comb begin
		logic [AW-1:0] g;
		logic [AW-1:0] p;
		g = adv_raw;
		p = {star_v, 1'b0};
		for (int l = 0; l < LV; l++) begin
			g = g | (p & (g << (1 << l)));
			p = p & (p << (1 << l));
		end
		adv_closed = g;
	end

	always_comb begin
		wr_en    = 1'b0;
		wr_kind  = gwm_pkg::KIND_LIT;
		wr_byte  = pc_s1;
		count_n  = count_q;
		active_n = active_q;
		esc_n    = esc_q;
		begun_n  = begun_q;
		err_n    = gwm_pkg::ERR_NONE;
		case (cmd_s1)
			gwm_pkg::CMD_START: begin
				count_n  = '0;
				active_n = AW'(1);
				esc_n    = 1'b0;
				begun_n  = 1'b0;
			end
			gwm_pkg::CMD_PATTERN: begin
				if (begun_q) begin
					err_n = gwm_pkg::ERR_AFTER_TEXT;
				end else if (esc_q) begin
					wr_en = 1'b1;
					esc_n = 1'b0;
				end else if (count_q >= MAX_CNT) begin
					err_n = gwm_pkg::ERR_OVERFLOW;
				end else if (pc_s1 == gwm_pkg::ESC_BYTE) begin
					esc_n = 1'b1;
				end else begin
					wr_en = 1'b1;
					if (pc_s1 == gwm_pkg::STAR_BYTE) begin
						wr_kind = gwm_pkg::KIND_STAR;
					end else if (pc_s1 == gwm_pkg::QMARK_BYTE) begin
						wr_kind = gwm_pkg::KIND_ANY;
					end
				end
				// active set is the closure of position zero; a new star extends it by one
				if (wr_en && (wr_kind == gwm_pkg::KIND_STAR) && active_q[count_q]) begin
					active_n = active_q | ((AW'(1) << count_q) << 1);
				end
			end
			gwm_pkg::CMD_TEXT: begin
				if (tc_s1 == 8'd0) begin
					err_n = gwm_pkg::ERR_ZERO_TEXT;
				end else begin
					begun_n  = 1'b1;
					esc_n    = 1'b0;
					wr_en    = esc_fill;
					wr_byte  = gwm_pkg::ESC_BYTE;
					active_n = adv_closed;
				end
			end
			default: begin
			end
		endcase
		if (wr_en) begin
			count_n = count_q + 1'b1;
		end
		matched_n = active_n[count_n] && !esc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			active_q <= AW'(1);
			esc_q    <= 1'b0;
			begun_q  <= 1'b0;
		end else if (step) begin
			count_q  <= count_n;
			active_q <= active_n;
			esc_q    <= esc_n;
			begun_q  <= begun_n;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_TOKENS; i++) begin
			if (step && wr_en && (count_q == CW'(i))) begin
				kind_q[i] <= wr_kind;
				byte_q[i] <= wr_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			matched_q <= matched_n;
			err_q     <= err_n;
			held_q    <= 6'(count_n);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'd0, held_q, err_q, matched_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("token count beyond capacity");

	a_no_esc_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		begun_q |-> !esc_q)
		else $error("backslash pending after text began");

	a_active_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((active_q >> count_q) >> 1) == '0)
		else $error("active position beyond token count");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> m_tvalid)
		else $error("request processed without a result");

endmodule

// ===== tb/glob_wildcard_matcher_test.sv =====
// Self-checking bench for the glob matcher: random-stall stream driver, monitor and predictor.
`timescale 1ns / 1ps
module glob_wildcard_matcher_test;

	localparam int            MAX_TOK    = 32;
	localparam gwm_pkg::cmd_t CMD_IDLE   = 2'd3;
	localparam int            STUCK_MAX  = 2000;
	localparam int            ITEMS_GOAL = 1450;

	typedef struct packed {
		logic          matched;
		gwm_pkg::err_t err;
		logic [5:0]    tokens;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [1:0] cmd, [9:2] pattern_char, [17:10] text_char
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [0] matched, [2:1] error_code, [8:3] tokens_held

	glob_wildcard_matcher #(.MAX_TOKENS(MAX_TOK)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// predictor state
	gwm_pkg::kind_t   tok_kind [MAX_TOK];
	logic [7:0]       tok_byte [MAX_TOK];
	int               n_tok;
	logic [MAX_TOK:0] live;
	bit               esc_held;
	bit               text_on;

	logic [23:0] requests_to_send[$];
	verdict_t    verdicts_due[$];
	int          total_requests;
	int          sent_count;
	int          result_count;
	int          match_count;
	int          err_seen [4];
	int          fail_count;
	int          stuck;
	int          src_gap;
	int          sink_gap;
	bit          req_taken;

	function automatic logic [MAX_TOK:0] close_stars(input logic [MAX_TOK:0] s);
		for (int i = 0; i < n_tok; i++)
			if (s[i] && tok_kind[i] == gwm_pkg::KIND_STAR)
				s[i + 1] = 1'b1;
		return s;
	endfunction

	function automatic void push_token(input gwm_pkg::kind_t k, input logic [7:0] b);
		if (n_tok < MAX_TOK) begin
			tok_kind[n_tok] = k;
			tok_byte[n_tok] = b;
			n_tok++;
		end
	endfunction

	function automatic logic [MAX_TOK:0] step_text(input logic [MAX_TOK:0] s,
			input logic [7:0] ch);
		logic [MAX_TOK:0] nx;
		nx = '0;
		for (int i = 0; i < n_tok; i++) begin
			if (s[i]) begin
				if (tok_kind[i] == gwm_pkg::KIND_STAR)
					nx[i] = 1'b1;
				else if (tok_kind[i] == gwm_pkg::KIND_ANY || tok_byte[i] == ch)
					nx[i + 1] = 1'b1;
			end
		end
		return close_stars(nx);
	endfunction

	function automatic void clear_matcher();
		n_tok    = 0;
		live     = (MAX_TOK + 1)'(1);
		esc_held = 1'b0;
		text_on  = 1'b0;
	endfunction

	function automatic void predict_verdict(input logic [23:0] d);
		gwm_pkg::cmd_t c;
		logic [7:0]    pc;
		logic [7:0]    tc;
		verdict_t      v;
		c  = d[1:0];
		pc = d[9:2];
		tc = d[17:10];
		v.err = gwm_pkg::ERR_NONE;
		case (c)
			gwm_pkg::CMD_START: clear_matcher();
			gwm_pkg::CMD_PATTERN: begin
				if (text_on)
					v.err = gwm_pkg::ERR_AFTER_TEXT;
				else if (esc_held) begin
					push_token(gwm_pkg::KIND_LIT, pc);
					esc_held = 1'b0;
				end else if (n_tok >= MAX_TOK)
					v.err = gwm_pkg::ERR_OVERFLOW;
				else if (pc == gwm_pkg::ESC_BYTE)
					esc_held = 1'b1;
				else if (pc == gwm_pkg::STAR_BYTE)
					push_token(gwm_pkg::KIND_STAR, pc);
				else if (pc == gwm_pkg::QMARK_BYTE)
					push_token(gwm_pkg::KIND_ANY, pc);
				else
					push_token(gwm_pkg::KIND_LIT, pc);
				if (!text_on)
					live = close_stars((MAX_TOK + 1)'(1));
			end
			gwm_pkg::CMD_TEXT: begin
				if (tc == 8'h00)
					v.err = gwm_pkg::ERR_ZERO_TEXT;
				else begin
					if (!text_on) begin
						// a trailing backslash becomes a literal one
						text_on = 1'b1;
						if (esc_held) begin
							push_token(gwm_pkg::KIND_LIT, gwm_pkg::ESC_BYTE);
							esc_held = 1'b0;
						end
						live = close_stars((MAX_TOK + 1)'(1));
					end
					live = step_text(live, tc);
				end
			end
			default: ;
		endcase
		v.matched = esc_held ? 1'b0 : live[n_tok];
		v.tokens  = 6'(n_tok);
		verdicts_due.push_back(v);
	endfunction

	// unused field of each request carries random bits
	function automatic void add_request(input gwm_pkg::cmd_t c, input logic [7:0] b);
		logic [7:0] pc;
		logic [7:0] tc;
		pc = (c == gwm_pkg::CMD_PATTERN) ? b : 8'($urandom);
		tc = (c == gwm_pkg::CMD_TEXT) ? b : 8'($urandom);
		requests_to_send.push_back({6'b0, tc, pc, c});
	endfunction

	function automatic logic [7:0] rand_pattern_byte();
		case ($urandom_range(0, 11))
			0, 1, 2, 3: return 8'h61 + 8'($urandom_range(0, 1));
			4, 5:       return gwm_pkg::STAR_BYTE;
			6:          return gwm_pkg::QMARK_BYTE;
			7:          return gwm_pkg::ESC_BYTE;
			8:          return 8'h63;
			default:    return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] rand_text_byte();
		case ($urandom_range(0, 13))
			0:       return 8'h00;
			1:       return gwm_pkg::ESC_BYTE;
			2:       return gwm_pkg::STAR_BYTE;
			3:       return gwm_pkg::QMARK_BYTE;
			4:       return 8'($urandom);
			5:       return 8'h63;
			default: return 8'h61 + 8'($urandom_range(0, 1));
		endcase
	endfunction

	function automatic bit idling_allowed();
		return requests_to_send.size() > 250 && (requests_to_send.size() / 150) % 3 != 0;
	endfunction

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			m_tready <= 1'b0;
		end else begin
			if (!s_tvalid || req_taken) begin
				if (src_gap > 0) begin
					s_tvalid <= 1'b0;
					src_gap--;
				end else if (requests_to_send.size() == 0)
					s_tvalid <= 1'b0;
				else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
					src_gap = $urandom_range(0, 16);
					s_tvalid <= 1'b0;
				end else begin
					s_tdata  <= requests_to_send.pop_front();
					s_tvalid <= 1'b1;
				end
			end
			req_taken = 1'b0;
			if (sink_gap > 0) begin
				m_tready <= 1'b0;
				sink_gap--;
			end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
				sink_gap = $urandom_range(0, 16);
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (!arst_n) begin
			clear_matcher();
		end else begin
			if (s_tvalid && s_tready) begin
				predict_verdict(s_tdata);
				req_taken = 1'b1;
				sent_count++;
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[0], m_tdata[2:1], m_tdata[8:3]};
				result_count++;
				match_count += got.matched;
				err_seen[got.err]++;
				if (verdicts_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %p at %0t", got, $realtime);
				end else begin
					want = verdicts_due.pop_front();
					if (got.matched != want.matched || got.err != want.err
							|| got.tokens != want.tokens) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result %0d: want m=%0b e=%0d t=%0d, got m=%0b e=%0d t=%0d",
								result_count, want.matched, want.err, want.tokens,
								got.matched, got.err, got.tokens);
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck = 0;
			else
				stuck++;
			if (stuck == STUCK_MAX) begin
				$display("watchdog: no handshake for %0d cycles", STUCK_MAX);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int plen;
		int tlen;
		arst_n = 1'b0;

		// directed: escapes, wildcards, byte extremes, errors, spare command
		add_request(gwm_pkg::CMD_START, 8'hFF);
		add_request(gwm_pkg::CMD_PATTERN, gwm_pkg::ESC_BYTE);
		add_request(gwm_pkg::CMD_PATTERN, gwm_pkg::STAR_BYTE);
		add_request(gwm_pkg::CMD_PATTERN, gwm_pkg::QMARK_BYTE);
		add_request(gwm_pkg::CMD_PATTERN, gwm_pkg::STAR_BYTE);
		add_request(gwm_pkg::CMD_PATTERN, 8'hFF);
		add_request(gwm_pkg::CMD_PATTERN, gwm_pkg::ESC_BYTE);
		add_request(gwm_pkg::CMD_TEXT, 8'h00);
		add_request(gwm_pkg::CMD_TEXT, gwm_pkg::STAR_BYTE);
		add_request(gwm_pkg::CMD_TEXT, 8'h78);
		add_request(gwm_pkg::CMD_PATTERN, 8'h61);
		add_request(gwm_pkg::CMD_TEXT, 8'hFF);
		add_request(gwm_pkg::CMD_TEXT, gwm_pkg::ESC_BYTE);
		add_request(CMD_IDLE, 8'hFF);
		add_request(gwm_pkg::CMD_START, 8'h00);
		add_request(gwm_pkg::CMD_TEXT, 8'h01);
		add_request(gwm_pkg::CMD_START, 8'h00);
		add_request(gwm_pkg::CMD_PATTERN, 8'h00);
		add_request(gwm_pkg::CMD_TEXT, 8'h01);
		add_request(gwm_pkg::CMD_START, 8'h00);
		add_request(gwm_pkg::CMD_PATTERN, gwm_pkg::STAR_BYTE);
		add_request(gwm_pkg::CMD_TEXT, 8'hFF);
		add_request(CMD_IDLE, 8'h00);

		// random match sessions; one in ten builds a pattern of 28 to 36 bytes, which can overflow
		while (requests_to_send.size() < ITEMS_GOAL) begin
			add_request(gwm_pkg::CMD_START, 8'($urandom));
			plen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 6);
			tlen = $urandom_range(0, 8);
			for (int i = 0; i < plen; i++) begin
				if ($urandom_range(0, 24) == 0)
					add_request(CMD_IDLE, 8'($urandom));
				add_request(gwm_pkg::CMD_PATTERN, rand_pattern_byte());
			end
			for (int i = 0; i < tlen; i++) begin
				if ($urandom_range(0, 15) == 0)
					add_request(gwm_pkg::CMD_PATTERN, rand_pattern_byte());
				else if ($urandom_range(0, 24) == 0)
					add_request(CMD_IDLE, 8'($urandom));
				add_request(gwm_pkg::CMD_TEXT, rand_text_byte());
			end
		end
		total_requests = requests_to_send.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (sent_count < total_requests)
			@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Covered %0d requests and %0d results, %0d of them matches.",
			sent_count, result_count, match_count);
		$display("Error codes seen: overflow %0d, pattern after text %0d, zero text %0d.",
			err_seen[gwm_pkg::ERR_OVERFLOW], err_seen[gwm_pkg::ERR_AFTER_TEXT],
			err_seen[gwm_pkg::ERR_ZERO_TEXT]);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
